// ===== rtl/fptw_pkg.sv =====
// Shared types, codes and mask helpers for the four-level page table walker.
// No dependencies; imported by fptw_step and the top level.
`timescale 1ns / 1ps

package fptw_pkg;

   localparam int PA_W    = 52;
   localparam int VA_W    = 48;
   localparam int FRAME_W = 40;
   localparam int IDX_W   = 9;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_ENTRY = 1'b1;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // walk status codes
   localparam logic [2:0] STATUS_4K       = 3'd0;
   localparam logic [2:0] STATUS_2M       = 3'd1;
   localparam logic [2:0] STATUS_1G       = 3'd2;
   localparam logic [2:0] STATUS_NOT_PRES = 3'd3;
   localparam logic [2:0] STATUS_IDLE     = 3'd4;

   localparam logic [1:0] LEVEL_TOP  = 2'd3;
   localparam logic [1:0] LEVEL_1G   = 2'd2;
   localparam logic [1:0] LEVEL_2M   = 2'd1;
   localparam logic [1:0] LEVEL_LAST = 2'd0;

   localparam int PRESENT_BIT   = 0;
   localparam int PAGE_SIZE_BIT = 7;

   localparam logic [PA_W-1:0] FRAME_BITS = 52'h000FFFFFFFFFF000;
   localparam logic [PA_W-1:0] GIG_BITS   = 52'h000FFFFFC0000000;
   localparam logic [PA_W-1:0] MEG2_BITS  = 52'h000FFFFFFFE00000;
   localparam logic [PA_W-1:0] OFS_1G     = 52'h3FFFFFFF;
   localparam logic [PA_W-1:0] OFS_2M     = 52'h1FFFFF;
   localparam logic [PA_W-1:0] OFS_4K     = 52'hFFF;

   typedef struct packed {
      logic               active;
      logic [1:0]         level;
      logic [VA_W-1:0]    va;
      logic [FRAME_W-1:0] frame;
   } walk_state_type;

   typedef struct packed {
      logic            kind;
      logic [PA_W-1:0] read_addr;
      logic [PA_W-1:0] phys_addr;
      logic [2:0]      status;
      logic [1:0]      level;
   } walk_result_type;

   // implemented physical address bits as a mask
   function automatic logic [PA_W-1:0] phys_mask(input int bits);
      logic [63:0] m;
      m = (64'd1 << bits) - 64'd1;
      return m[PA_W-1:0];
   endfunction

endpackage

// ===== rtl/fptw_step.sv =====
// One walk step: next walk state and result from the current state and a request.
// Depends on fptw_pkg.
`timescale 1ns / 1ps

module fptw_step import fptw_pkg::*; #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  logic               op,
   input  logic [63:0]        virt_addr,
   input  logic [63:0]        entry_data,
   input  logic [FRAME_W-1:0] root_frame,
   input  walk_state_type     cur,
   output walk_state_type     nxt,
   output walk_result_type    res
);

   localparam logic [PA_W-1:0] PMASK      = phys_mask(PHYS_ADDR_BITS);
   localparam logic [PA_W-1:0] FRAME_MASK = PMASK & FRAME_BITS;
   localparam logic [PA_W-1:0] GIG_MASK   = PMASK & GIG_BITS;
   localparam logic [PA_W-1:0] MEG2_MASK  = PMASK & MEG2_BITS;

   logic [PA_W-1:0]  entry_pa;
   logic [PA_W-1:0]  va_pa;
   logic [PA_W-1:0]  entry_frame;
   logic [IDX_W-1:0] idx;

   assign entry_pa    = entry_data[PA_W-1:0];
   assign va_pa       = PA_W'(cur.va);
   assign entry_frame = entry_pa & FRAME_MASK;

   always_comb begin
      nxt           = cur;
      idx           = '0;
      res.kind      = KIND_DONE;
      res.read_addr = '0;
      res.phys_addr = '0;
      res.status    = STATUS_4K;
      res.level     = cur.level;

      if (op == OP_START) begin
         nxt.active = 1'b1;
         nxt.level  = LEVEL_TOP;
         nxt.va     = virt_addr[VA_W-1:0];
         nxt.frame  = root_frame;
         res.kind   = KIND_READ;
      end else if (!cur.active) begin
         res.status = STATUS_IDLE;
         res.level  = LEVEL_LAST;
      end else if (!entry_data[PRESENT_BIT]) begin
         nxt.active = 1'b0;
         res.status = STATUS_NOT_PRES;
      end else if (cur.level == LEVEL_LAST) begin
         nxt.active    = 1'b0;
         res.phys_addr = entry_frame | (va_pa & OFS_4K);
         res.status    = STATUS_4K;
      end else if (entry_data[PAGE_SIZE_BIT] && cur.level == LEVEL_1G) begin
         nxt.active    = 1'b0;
         res.phys_addr = (entry_pa & GIG_MASK) | (va_pa & OFS_1G);
         res.status    = STATUS_1G;
      end else if (entry_data[PAGE_SIZE_BIT] && cur.level == LEVEL_2M) begin
         nxt.active    = 1'b0;
         res.phys_addr = (entry_pa & MEG2_MASK) | (va_pa & OFS_2M);
         res.status    = STATUS_2M;
      end else begin
         nxt.level = cur.level - 2'd1;
         nxt.frame = entry_frame[PA_W-1:12];
         res.kind  = KIND_READ;
      end

      if (res.kind == KIND_READ) begin
         // index of the entry to read next, picked by the level being read
         case (nxt.level)
            LEVEL_TOP:  idx = nxt.va[47:39];
            LEVEL_1G:   idx = nxt.va[38:30];
            LEVEL_2M:   idx = nxt.va[29:21];
            default:    idx = nxt.va[20:12];
         endcase
         res.level     = nxt.level;
         res.read_addr = (({nxt.frame, 12'h000}) & FRAME_MASK)
                         + PA_W'({idx, 3'b000});
      end
   end

endmodule

// ===== rtl/four_level_page_table_walker_top.sv =====
// Four-level page table walker, top level: request/result handshakes, walk state.
// Depends on fptw_pkg and fptw_step.
//
// Usage:
//   Request channel (req_*): op 0 starts a walk for req_virt_addr; op 1 returns
//   the 64-bit entry that the last read result asked for. Every request gives
//   exactly one result on the rsp_* channel: a read address for the next
//   entry, or a finished walk (4KB/2MB/1GB address, not present, or idle when
//   entry data comes with no walk running).
//   csr_wr_en/csr_wr_data load the top-level table base; write it while idle.
//   A request in the input register goes through the walk step to the result
//   register. Throughput: one request per cycle unless rsp_stall holds a result;
//   both stages advance together, and the walk state updates as each request
//   leaves the input register.
//   The caller must wait for a read result before sending the entry for it.
//   rsp_stall holds the result register; the input register still fills, and
//   req_stall rises only when both stages are full.
//   Reset (synchronous) clears the walk state, the table base and both valids.
`timescale 1ns / 1ps

module four_level_page_table_walker_top import fptw_pkg::*; #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [PA_W-1:0] csr_wr_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_op,
   input  logic [63:0]     req_virt_addr,
   input  logic [63:0]     req_entry_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_result_kind,
   output logic [PA_W-1:0] rsp_read_addr,
   output logic [PA_W-1:0] rsp_phys_addr,
   output logic [2:0]      rsp_status,
   output logic [1:0]      rsp_walk_level
);

   localparam logic [PA_W-1:0] ROOT_MASK = phys_mask(PHYS_ADDR_BITS) & FRAME_BITS;

   logic [FRAME_W-1:0] root_frame_ff, root_frame_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_op_ff;
   logic [63:0]        s1_va_ff;
   logic [63:0]        s1_entry_ff;
   walk_state_type     state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   walk_result_type    rsp_ff, step_res;

   logic out_free;
   logic s1_move;
   logic req_accept;
   logic [PA_W-1:0] root_masked;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign root_masked   = csr_wr_data & ROOT_MASK;
   assign root_frame_in = csr_wr_en ? root_masked[PA_W-1:12] : root_frame_ff;
   assign s1_valid_in   = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in  = s1_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   fptw_step #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_step (
      .op         (s1_op_ff),
      .virt_addr  (s1_va_ff),
      .entry_data (s1_entry_ff),
      .root_frame (root_frame_ff),
      .cur        (state_ff),
      .nxt        (state_in),
      .res        (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         root_frame_ff <= root_frame_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (s1_move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_op;
         s1_va_ff    <= req_virt_addr;
         s1_entry_ff <= req_entry_data;
      end
      if (s1_move) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_ff.kind;
   assign rsp_read_addr   = rsp_ff.read_addr;
   assign rsp_phys_addr   = rsp_ff.phys_addr;
   assign rsp_status      = rsp_ff.status;
   assign rsp_walk_level  = rsp_ff.level;

   // a start that leaves the input register leaves a walk at the top level
   a_start_sets_top: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_op_ff == OP_START |=> state_ff.active && state_ff.level == LEVEL_TOP)
      else $error("start did not open a walk at the top level");

   // a held request in the input register stays put
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff)
      else $error("input register dropped a request");

   // read results carry no finish information
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_READ |-> rsp_ff.phys_addr == '0
         && rsp_ff.status == STATUS_4K)
      else $error("read result carries finish fields");

   // a finished walk leaves no walk active
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      s1_move && step_res.kind == KIND_DONE |=> !state_ff.active)
      else $error("walk still active after finish");

endmodule

// ===== sim/tb.sv =====
// Testbench for four_level_page_table_walker_top: directed table, then random walks.
// Depends on fptw_pkg and the walker RTL; holds its own predictor of the walk.
`timescale 1ns / 1ps

module tb import fptw_pkg::*; ();

   localparam int QUIET_LIMIT = 2000;
   localparam int WALK_ITEMS = 450;
   localparam int NUM_ROWS = 26;
   localparam logic [63:0] ALL1 = '1;
   localparam walk_result_type NO_RES = '0;

   typedef struct packed {
      logic            op;
      logic [63:0]     vaddr;
      logic [63:0]     entry;
      logic            known;
      walk_result_type want;
   } stim_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_wr_en = 1'b0;
   logic [PA_W-1:0] csr_wr_data = '0;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic            req_op = OP_START;
   logic [63:0]     req_virt_addr = '0;
   logic [63:0]     req_entry_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic            rsp_result_kind;
   logic [PA_W-1:0] rsp_read_addr;
   logic [PA_W-1:0] rsp_phys_addr;
   logic [2:0]      rsp_status;
   logic [1:0]      rsp_walk_level;

   // predicted walk state
   logic               pred_walking = 1'b0;
   logic [1:0]         pred_level = '0;
   logic [VA_W-1:0]    pred_va = '0;
   logic [FRAME_W-1:0] pred_frame = '0;
   logic [PA_W-1:0]    pred_root = '0;

   walk_result_type pending_results [$];
   stim_row_type    dir_rows [NUM_ROWS];
   int              mismatches = 0;
   int              quiet_cycles = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              send_idle_plan [4] = '{0, 60, 0, 14};
   int              stall_plan [4] = '{0, 0, 60, 14};
   logic [PA_W-1:0] root_val;

   four_level_page_table_walker_top uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_virt_addr   (req_virt_addr),
      .req_entry_data  (req_entry_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_addr   (rsp_read_addr),
      .rsp_phys_addr   (rsp_phys_addr),
      .rsp_status      (rsp_status),
      .rsp_walk_level  (rsp_walk_level)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic walk_result_type read_res(input logic [PA_W-1:0] addr,
                                                input logic [1:0] lvl);
      walk_result_type r;
      r = '0;
      r.kind = KIND_READ;
      r.read_addr = addr;
      r.level = lvl;
      return r;
   endfunction

   function automatic walk_result_type done_res(input logic [PA_W-1:0] paddr,
                                                input logic [2:0] stat,
                                                input logic [1:0] lvl);
      walk_result_type r;
      r = '0;
      r.kind = KIND_DONE;
      r.phys_addr = paddr;
      r.status = stat;
      r.level = lvl;
      return r;
   endfunction

   // entry address for the table at pred_frame, indexed by the held VA at pred_level
   function automatic walk_result_type table_read();
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(pred_va >> (12 + 9 * pred_level));
      return read_res({pred_frame, 12'h000} + PA_W'({idx, 3'b000}), pred_level);
   endfunction

   function automatic walk_result_type walk_predict(input logic op,
                                                    input logic [63:0] vaddr,
                                                    input logic [63:0] entry);
      walk_result_type r;
      if (op == OP_START) begin
         pred_va = vaddr[VA_W-1:0];
         pred_frame = pred_root[PA_W-1:12];
         pred_level = LEVEL_TOP;
         pred_walking = 1'b1;
         r = table_read();
      end else if (!pred_walking) begin
         r = done_res('0, STATUS_IDLE, LEVEL_LAST);
      end else if (!entry[PRESENT_BIT]) begin
         pred_walking = 1'b0;
         r = done_res('0, STATUS_NOT_PRES, pred_level);
      end else if (pred_level == LEVEL_LAST) begin
         // page-size bit means nothing in the last table
         pred_walking = 1'b0;
         r = done_res({entry[PA_W-1:12], pred_va[11:0]}, STATUS_4K, pred_level);
      end else if (entry[PAGE_SIZE_BIT] && pred_level == LEVEL_1G) begin
         pred_walking = 1'b0;
         r = done_res({entry[PA_W-1:30], pred_va[29:0]}, STATUS_1G, pred_level);
      end else if (entry[PAGE_SIZE_BIT] && pred_level == LEVEL_2M) begin
         pred_walking = 1'b0;
         r = done_res({entry[PA_W-1:21], pred_va[20:0]}, STATUS_2M, pred_level);
      end else begin
         pred_frame = entry[PA_W-1:12];
         pred_level = pred_level - 2'd1;
         r = table_read();
      end
      return r;
   endfunction

   task automatic drain();
      while (pending_results.size() != 0) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic op, input logic [63:0] vaddr,
                               input logic [63:0] entry, input logic known,
                               input walk_result_type want);
      walk_result_type r;
      // entry data only goes out once the read it answers has come back
      if (op == OP_ENTRY)
         drain();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_virt_addr = vaddr;
      req_entry_data = entry;
      do @(posedge clock); while (req_stall);
      r = walk_predict(op, vaddr, entry);
      pending_results.push_back(known ? want : r);
      @(negedge clock);
   endtask

   task automatic write_root(input logic [PA_W-1:0] value);
      drain();
      req_valid = 1'b0;
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      pred_root = value;
   endtask

   task automatic random_walks(input int n);
      int sent;
      logic [63:0] e;
      sent = 0;
      while (sent < n) begin
         if (!pred_walking && $urandom_range(9) == 0) begin
            // stray entry data, no walk running
            send_request(OP_ENTRY, rand64(), rand64(), 1'b0, NO_RES);
         end else if (!pred_walking || $urandom_range(19) == 0) begin
            send_request(OP_START, rand64(), rand64(), 1'b0, NO_RES);
         end else begin
            e = rand64();
            e[PRESENT_BIT] = ($urandom_range(9) != 0);
            e[PAGE_SIZE_BIT] = ($urandom_range(3) == 0);
            send_request(OP_ENTRY, rand64(), e, 1'b0, NO_RES);
         end
         sent++;
      end
   endtask

   always @(negedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : result_check
      walk_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with no request waiting");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_result_kind);
               mismatches++;
            end
            if (rsp_read_addr !== want.read_addr) begin
               $error("read_addr: expected %h, got %h", want.read_addr, rsp_read_addr);
               mismatches++;
            end
            if (rsp_phys_addr !== want.phys_addr) begin
               $error("phys_addr: expected %h, got %h", want.phys_addr, rsp_phys_addr);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_walk_level !== want.level) begin
               $error("walk_level: expected %0d, got %0d", want.level, rsp_walk_level);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      // table base still at its reset value of zero for these rows
      dir_rows[0]  = '{OP_ENTRY, 64'h0, ALL1, 1'b1, done_res('0, STATUS_IDLE, LEVEL_LAST)};
      dir_rows[1]  = '{OP_START, 64'h0, 64'h0, 1'b1, read_res('0, LEVEL_TOP)};
      dir_rows[2]  = '{OP_ENTRY, ALL1, 64'h0, 1'b1, done_res('0, STATUS_NOT_PRES, LEVEL_TOP)};
      dir_rows[3]  = '{OP_ENTRY, 64'h0, ALL1, 1'b1, done_res('0, STATUS_IDLE, LEVEL_LAST)};
      dir_rows[4]  = '{OP_START, ALL1, 64'h0, 1'b1, read_res(52'hFF8, LEVEL_TOP)};
      dir_rows[5]  = '{OP_ENTRY, 64'h0, ALL1, 1'b0, NO_RES};
      dir_rows[6]  = '{OP_ENTRY, 64'h0, ALL1, 1'b1,
                       done_res(52'hF_FFFF_FFFF_FFFF, STATUS_1G, LEVEL_1G)};
      dir_rows[7]  = '{OP_START, ALL1, ALL1, 1'b0, NO_RES};
      dir_rows[8]  = '{OP_ENTRY, 64'h0, 64'hFFF0_0000_0000_0001, 1'b0, NO_RES};
      dir_rows[9]  = '{OP_ENTRY, 64'h0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b0, NO_RES};
      dir_rows[10] = '{OP_ENTRY, 64'h0, ALL1, 1'b1,
                       done_res(52'hF_FFFF_FFFF_FFFF, STATUS_2M, LEVEL_2M)};
      dir_rows[11] = '{OP_START, 64'h0000_7F80_C060_3ABC, 64'h0, 1'b0, NO_RES};
      dir_rows[12] = '{OP_ENTRY, 64'h0, 64'h1, 1'b0, NO_RES};
      dir_rows[13] = '{OP_ENTRY, 64'h0, 64'h1, 1'b0, NO_RES};
      dir_rows[14] = '{OP_ENTRY, 64'h0, 64'h1, 1'b0, NO_RES};
      dir_rows[15] = '{OP_ENTRY, 64'h0, ALL1, 1'b0, NO_RES};
      dir_rows[16] = '{OP_START, 64'h1234_5678_9ABC_DEF0, 64'h0, 1'b0, NO_RES};
      dir_rows[17] = '{OP_ENTRY, 64'h0, 64'h0000_000A_BCDE_F081, 1'b0, NO_RES};
      // new start abandons the walk in flight
      dir_rows[18] = '{OP_START, 64'hFFFF_8000_0000_0000, 64'h0, 1'b0, NO_RES};
      dir_rows[19] = '{OP_ENTRY, 64'h0, ALL1, 1'b0, NO_RES};
      dir_rows[20] = '{OP_ENTRY, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
                       done_res('0, STATUS_NOT_PRES, LEVEL_1G)};
      dir_rows[21] = '{OP_START, 64'h0, 64'h0, 1'b0, NO_RES};
      dir_rows[22] = '{OP_ENTRY, 64'h0, 64'h1, 1'b0, NO_RES};
      dir_rows[23] = '{OP_ENTRY, 64'h0, 64'h1, 1'b0, NO_RES};
      dir_rows[24] = '{OP_ENTRY, 64'h0, 64'h1, 1'b0, NO_RES};
      dir_rows[25] = '{OP_ENTRY, 64'h0, 64'h80, 1'b1,
                       done_res('0, STATUS_NOT_PRES, LEVEL_LAST)};

      repeat (10) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++)
         send_request(dir_rows[i].op, dir_rows[i].vaddr, dir_rows[i].entry,
                      dir_rows[i].known, dir_rows[i].want);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: root_val = '1;
            1: root_val = PA_W'(rand64());
            2: root_val = '0;
            default: root_val = 52'hF_FFFF_FFFF_F000;
         endcase
         write_root(root_val);
         send_idle_pct = send_idle_plan[p];
         stall_pct = stall_plan[p];
         random_walks(WALK_ITEMS);
      end

      drain();
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
